>>> hw/rtl/lfh_pkg.sv
`default_nettype none
package lfh_pkg;

    // sequencer steps for one tick
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODE,
        ST_DIV,
        ST_ERR,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic mode_upd;
        logic div_step;
        logic err_calc;
        logic mul;
        logic sum;
        logic fin;
    } lfh_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } lfh_status_t;

    localparam logic [2:0] MODE_TRACK = 3'd0;
    localparam logic [2:0] MODE_ADV   = 3'd1;
    localparam logic [2:0] MODE_BLIND = 3'd2;
    localparam logic [2:0] MODE_TL    = 3'd3;
    localparam logic [2:0] MODE_TR    = 3'd4;

    localparam logic [2:0] REG_TRACK_BASE = 3'd0;
    localparam logic [2:0] REG_MAX_SPEED  = 3'd1;
    localparam logic [2:0] REG_LINE_KP    = 3'd2;
    localparam logic [2:0] REG_LINE_KD    = 3'd3;
    localparam logic [2:0] REG_HEAD_KP    = 3'd4;
    localparam logic [2:0] REG_HEAD_KD    = 3'd5;
    localparam logic [2:0] REG_BLIND_BASE = 3'd6;
    localparam logic [2:0] REG_TURN_SPEED = 3'd7;

    localparam logic signed [19:0] DEG180     = 20'sd46080;
    localparam logic signed [19:0] DEG360     = 20'sd92160;
    localparam logic signed [17:0] TURN_Q8    = 18'sd20480;
    localparam logic signed [16:0] TOL_Q8     = 17'sd1280;
    localparam logic signed [19:0] HMAX_Q12   = 20'sd409600;
    localparam logic signed [12:0] BLIND_COMP = -13'sd5;

    // divider runs 13 quotient bits: counts 0..12
    localparam logic [3:0] DIV_LAST = 4'd12;

    function automatic logic signed [3:0] line_weight(input logic [2:0] idx);
        logic signed [3:0] w;
        case (idx)
            3'd0: w = -4'sd7;
            3'd1: w = -4'sd5;
            3'd2: w = -4'sd3;
            3'd3: w = -4'sd1;
            3'd4: w = 4'sd1;
            3'd5: w = 4'sd3;
            3'd6: w = 4'sd5;
            default: w = 4'sd7;
        endcase
        return w;
    endfunction

    // fold a heading difference into +-180 deg; two folds cover the input range
    function automatic logic signed [19:0] wrap_err(input logic signed [19:0] d);
        logic signed [19:0] r;
        r = d;
        if (r > DEG180) r = r - DEG360;
        else if (r < -DEG180) r = r + DEG360;
        if (r > DEG180) r = r - DEG360;
        else if (r < -DEG180) r = r + DEG360;
        return r;
    endfunction

    function automatic logic [9:0] clamp_speed(input logic signed [12:0] v,
                                               input logic [9:0] mx);
        logic [9:0] c;
        if (v < 13'sd0) c = 10'd0;
        else if (v > $signed({3'b000, mx})) c = mx;
        else c = v[9:0];
        return c;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/line_follow_heading_controller.sv
// Line-follow / heading controller, one item per 10 ms control tick.
// Input channel (s_*): line sensor bits, Q8 heading and heading-valid flag.
// Result channel (m_*): signed left/right wheel commands and the mode after
// the tick. Exactly one result item per input item.
// Config channel (cfg_*): index 0..7 selects a register, cfg_data holds the
// value; always ready, write only while the block is idle.
// From input accept to m_valid the sequencer steps through mode update, the
// restoring divider for the line position, error, multiply, sum/clamp and
// output. s_ready is high only in idle, so a new item is taken only after the
// last one has left the sequencer.
// The finished result sits in the output register, so a new item can be
// accepted while m_valid waits; if the receiver still stalls when the next
// result is ready, the sequencer holds in its output step.
// Reset (aresetn low, synchronous): mode track, tick counters and targets zero,
// registers back to defaults, no result pending.
`default_nettype none
module line_follow_heading_controller #(
    parameter int PRE_TURN_TICKS    = 80,
    parameter int MIN_TICKS_IN_MODE = 50,
    parameter int CONFIRM_TICKS     = 3
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_line_bits,
    input  wire logic signed [16:0] s_heading,
    input  wire logic               s_heading_valid,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [10:0]      m_left_drive,
    output logic signed [10:0]      m_right_drive,
    output logic [2:0]              m_mode,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [9:0]         cfg_data
);
    import lfh_pkg::*;

    lfh_cmd_t    cmd;
    lfh_status_t status;

    // config writes are never held off and land directly in their registers
    assign cfg_ready = 1'b1;

    lfh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    lfh_datapath #(
        .PRE_TURN_TICKS    (PRE_TURN_TICKS),
        .MIN_TICKS_IN_MODE (MIN_TICKS_IN_MODE),
        .CONFIRM_TICKS     (CONFIRM_TICKS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_line_bits     (s_line_bits),
        .s_heading       (s_heading),
        .s_heading_valid (s_heading_valid),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_left_drive    (m_left_drive),
        .m_right_drive   (m_right_drive),
        .m_mode          (m_mode)
    );

endmodule
`default_nettype wire

>>> hw/rtl/lfh_ctrl.sv
`default_nettype none
module lfh_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire lfh_pkg::lfh_status_t status,
    output lfh_pkg::lfh_cmd_t         cmd,
    output logic                      s_ready
);
    import lfh_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_MODE;
            ST_MODE: state_next = ST_DIV;
            ST_DIV:  if (status.div_done) state_next = ST_ERR;
            ST_ERR:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_OUT;
            ST_OUT:  if (status.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_MODE: cmd.mode_upd = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_ERR:  cmd.err_calc = 1'b1;
            ST_MUL:  cmd.mul = 1'b1;
            ST_SUM:  cmd.sum = 1'b1;
            ST_OUT:  cmd.fin = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/lfh_datapath.sv
`default_nettype none
module lfh_datapath #(
    parameter int PRE_TURN_TICKS    = 80,
    parameter int MIN_TICKS_IN_MODE = 50,
    parameter int CONFIRM_TICKS     = 3
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire lfh_pkg::lfh_cmd_t    cmd,
    output lfh_pkg::lfh_status_t      status,
    input  wire logic [7:0]           s_line_bits,
    input  wire logic signed [16:0]   s_heading,
    input  wire logic                 s_heading_valid,
    input  wire logic                 cfg_valid,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [9:0]           cfg_data,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output logic signed [10:0]        m_left_drive,
    output logic signed [10:0]        m_right_drive,
    output logic [2:0]                m_mode
);
    import lfh_pkg::*;

    // config
    logic [9:0] track_base_reg, max_speed_reg, blind_base_reg, turn_speed_reg;
    logic [7:0] line_kp_reg, line_kd_reg, head_kp_reg, head_kd_reg;

    // tick inputs
    logic [7:0]         bits_reg;
    logic signed [16:0] hdg_reg;
    logic               vld_reg;

    // mode state
    logic [2:0]         mode_reg, mode_next;
    logic [7:0]         ticks_reg, ticks_next;
    logic [2:0]         conf_reg, conf_next;
    logic [15:0]        tick_cnt_reg;
    logic [15:0]        adv_start_reg, adv_start_next;
    logic               pend_right_reg, pend_right_next;
    logic signed [17:0] last_hdg_reg, last_hdg_next;
    logic signed [17:0] blind_tgt_reg, blind_tgt_next;
    logic signed [17:0] turn_tgt_reg, turn_tgt_next;
    logic signed [11:0] prev_lerr_reg, prev_lerr_next;
    logic signed [16:0] prev_herr_reg, prev_herr_next;

    // divider
    logic [12:0] quo_reg;
    logic [3:0]  rem_reg, div_cnt_reg, nb_reg;
    logic        neg_reg;

    // pd arithmetic
    logic signed [11:0] err_reg;
    logic signed [16:0] herr_reg;
    logic signed [17:0] x_reg;
    logic signed [18:0] d_reg;
    logic [7:0]         g1_reg, g2_reg;
    logic signed [19:0] lim_reg;
    logic signed [27:0] p1_reg, p2_reg;
    logic signed [19:0] pd_reg;

    logic               out_valid_reg;
    logic signed [10:0] out_left_reg, out_right_reg;
    logic [2:0]         out_mode_reg;

    // line pattern
    logic [3:0]         nb;
    logic signed [5:0]  wsum;
    logic [4:0]         sum_mag;
    logic signed [17:0] hdg18;
    logic [7:0]         t1;
    logic [2:0]         c1;

    always_comb begin
        nb   = '0;
        wsum = '0;
        for (int i = 0; i < 8; i++) begin
            if (!bits_reg[i]) begin
                nb   = nb + 4'd1;
                wsum = wsum + 6'(line_weight(3'(i)));
            end
        end
        sum_mag = (wsum < 6'sd0) ? 5'(-wsum) : 5'(wsum);
    end

    assign hdg18 = 18'(hdg_reg);
    assign t1    = (ticks_reg == 8'hFF) ? ticks_reg : ticks_reg + 8'd1;
    assign c1    = (conf_reg == 3'd7) ? conf_reg : conf_reg + 3'd1;

    // divider step
    logic [4:0] rem_sh;
    logic       div_ge;
    assign rem_sh = {rem_reg, quo_reg[12]};
    assign div_ge = rem_sh >= {1'b0, nb_reg};

    // error stage
    logic               use_line;
    logic signed [11:0] err_val;
    logic signed [17:0] tgt;
    logic signed [19:0] e_full;
    logic signed [16:0] herr_val;
    assign use_line = (mode_reg == MODE_TRACK);
    assign err_val  = (nb_reg == 4'd0) ? prev_lerr_reg :
                      (neg_reg ? -$signed({1'b0, quo_reg[10:0]})
                               :  $signed({1'b0, quo_reg[10:0]}));
    assign tgt      = (mode_reg == MODE_BLIND) ? blind_tgt_reg : turn_tgt_reg;
    assign e_full   = wrap_err(20'(tgt) - 20'(hdg_reg));
    assign herr_val = $signed(e_full[16:0]);

    // pd sum and clamp
    logic signed [28:0] pd_sum;
    logic signed [19:0] pd_clamped;
    assign pd_sum     = 29'(p1_reg) + 29'(p2_reg);
    assign pd_clamped = (pd_sum > 29'(lim_reg))  ? lim_reg :
                        (pd_sum < -29'(lim_reg)) ? -lim_reg : 20'(pd_sum);

    // output stage
    logic signed [19:0] pd_r8, pd_r12;
    logic signed [12:0] q8, q12, base_s, bbs_s;
    logic [9:0]         spin_s, adv_s;
    logic               adv_done, turn_hit;
    assign pd_r8    = pd_reg + ((pd_reg < 20'sd0) ? 20'sd255 : 20'sd0);
    assign pd_r12   = pd_reg + ((pd_reg < 20'sd0) ? 20'sd4095 : 20'sd0);
    assign q8       = 13'(pd_r8 >>> 8);
    assign q12      = 13'(pd_r12 >>> 12);
    assign base_s   = $signed({3'b000, track_base_reg});
    assign bbs_s    = $signed({3'b000, blind_base_reg});
    assign spin_s   = clamp_speed($signed({3'b000, turn_speed_reg}), max_speed_reg);
    assign adv_s    = clamp_speed(bbs_s, max_speed_reg);
    assign adv_done = (tick_cnt_reg - adv_start_reg) >= 16'(PRE_TURN_TICKS);
    assign turn_hit = (herr_reg <= TOL_Q8) && (herr_reg >= -TOL_Q8);

    logic signed [10:0] left_val, right_val;

    always_comb begin
        mode_next       = mode_reg;
        ticks_next      = ticks_reg;
        conf_next       = conf_reg;
        adv_start_next  = adv_start_reg;
        pend_right_next = pend_right_reg;
        last_hdg_next   = last_hdg_reg;
        blind_tgt_next  = blind_tgt_reg;
        turn_tgt_next   = turn_tgt_reg;
        prev_lerr_next  = prev_lerr_reg;
        prev_herr_next  = prev_herr_reg;
        left_val        = '0;
        right_val       = '0;

        if (cmd.mode_upd && vld_reg) begin
            ticks_next = t1;
            case (mode_reg)
                MODE_TRACK: begin
                    if (nb != 4'd0) last_hdg_next = hdg18;
                    if (t1 < 8'(MIN_TICKS_IN_MODE)) begin
                        conf_next = '0;
                    end else if (bits_reg[7:4] == 4'd0 && bits_reg[3:0] != 4'd0 ||
                                 bits_reg[3:0] == 4'd0 && bits_reg[7:4] != 4'd0) begin
                        // all black on one side: go to the pre-turn advance
                        mode_next       = MODE_ADV;
                        pend_right_next = (bits_reg[3:0] == 4'd0);
                        adv_start_next  = tick_cnt_reg;
                        prev_herr_next  = '0;
                        ticks_next      = '0;
                        conf_next       = '0;
                    end else if (nb == 4'd0) begin
                        conf_next = c1;
                        if (c1 >= 3'(CONFIRM_TICKS)) begin
                            mode_next       = MODE_BLIND;
                            pend_right_next = 1'b0;
                            blind_tgt_next  = last_hdg_reg;
                            prev_herr_next  = '0;
                            ticks_next      = '0;
                            conf_next       = '0;
                        end
                    end else begin
                        conf_next = '0;
                    end
                end
                MODE_BLIND: begin
                    if (t1 >= 8'(MIN_TICKS_IN_MODE) && nb != 4'd0) begin
                        conf_next = c1;
                        if (c1 >= 3'(CONFIRM_TICKS)) begin
                            mode_next      = MODE_TRACK;
                            prev_lerr_next = '0;
                            ticks_next     = '0;
                            conf_next      = '0;
                        end
                    end else begin
                        conf_next = '0;
                    end
                end
                MODE_ADV, MODE_TL, MODE_TR: ticks_next = t1;
                default: begin
                    // undefined code: recover into track
                    mode_next      = MODE_TRACK;
                    prev_lerr_next = '0;
                    prev_herr_next = '0;
                    ticks_next     = '0;
                    conf_next      = '0;
                end
            endcase
        end

        if (cmd.fin && vld_reg) begin
            case (mode_reg)
                MODE_TRACK: begin
                    prev_lerr_next = err_reg;
                    left_val  = $signed({1'b0, clamp_speed(base_s - q8, max_speed_reg)});
                    right_val = -$signed({1'b0, clamp_speed(base_s + q8, max_speed_reg)});
                end
                MODE_BLIND: begin
                    prev_herr_next = herr_reg;
                    left_val  = $signed({1'b0,
                                 clamp_speed(bbs_s + BLIND_COMP - q12, max_speed_reg)});
                    right_val = -$signed({1'b0, clamp_speed(bbs_s + q12, max_speed_reg)});
                end
                MODE_ADV: begin
                    left_val  = $signed({1'b0, adv_s});
                    right_val = -$signed({1'b0, adv_s});
                    if (adv_done) begin
                        mode_next      = pend_right_reg ? MODE_TR : MODE_TL;
                        turn_tgt_next  = pend_right_reg ? hdg18 - TURN_Q8 : hdg18 + TURN_Q8;
                        prev_herr_next = '0;
                        ticks_next     = '0;
                        conf_next      = '0;
                    end
                end
                default: begin
                    if (turn_hit) begin
                        mode_next       = MODE_BLIND;
                        pend_right_next = 1'b0;
                        blind_tgt_next  = turn_tgt_reg;
                        prev_herr_next  = '0;
                        ticks_next      = '0;
                        conf_next       = '0;
                    end else if (mode_reg == MODE_TL) begin
                        left_val  = -$signed({1'b0, spin_s});
                        right_val = -$signed({1'b0, spin_s});
                    end else begin
                        left_val  = $signed({1'b0, spin_s});
                        right_val = $signed({1'b0, spin_s});
                    end
                end
            endcase
        end
    end

    // control and config state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_base_reg <= 10'd400;
            max_speed_reg  <= 10'd800;
            line_kp_reg    <= 8'd30;
            line_kd_reg    <= 8'd5;
            head_kp_reg    <= 8'd24;
            head_kd_reg    <= 8'd13;
            blind_base_reg <= 10'd280;
            turn_speed_reg <= 10'd180;
            mode_reg       <= MODE_TRACK;
            ticks_reg      <= '0;
            conf_reg       <= '0;
            tick_cnt_reg   <= '0;
            adv_start_reg  <= '0;
            pend_right_reg <= 1'b0;
            last_hdg_reg   <= '0;
            blind_tgt_reg  <= '0;
            turn_tgt_reg   <= '0;
            prev_lerr_reg  <= '0;
            prev_herr_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_TRACK_BASE: track_base_reg <= cfg_data;
                    REG_MAX_SPEED:  max_speed_reg  <= cfg_data;
                    REG_LINE_KP:    line_kp_reg    <= cfg_data[7:0];
                    REG_LINE_KD:    line_kd_reg    <= cfg_data[7:0];
                    REG_HEAD_KP:    head_kp_reg    <= cfg_data[7:0];
                    REG_HEAD_KD:    head_kd_reg    <= cfg_data[7:0];
                    REG_BLIND_BASE: blind_base_reg <= cfg_data;
                    REG_TURN_SPEED: turn_speed_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load) tick_cnt_reg <= tick_cnt_reg + 16'd1;
            mode_reg       <= mode_next;
            ticks_reg      <= ticks_next;
            conf_reg       <= conf_next;
            adv_start_reg  <= adv_start_next;
            pend_right_reg <= pend_right_next;
            last_hdg_reg   <= last_hdg_next;
            blind_tgt_reg  <= blind_tgt_next;
            turn_tgt_reg   <= turn_tgt_next;
            prev_lerr_reg  <= prev_lerr_next;
            prev_herr_reg  <= prev_herr_next;
            if (cmd.fin) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bits_reg <= s_line_bits;
            hdg_reg  <= s_heading;
            vld_reg  <= s_heading_valid;
        end
        if (cmd.mode_upd) begin
            quo_reg     <= {sum_mag, 8'd0};
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            nb_reg      <= nb;
            neg_reg     <= (wsum < 6'sd0);
        end
        if (cmd.div_step) begin
            rem_reg     <= div_ge ? 4'(rem_sh - {1'b0, nb_reg}) : rem_sh[3:0];
            quo_reg     <= {quo_reg[11:0], div_ge};
            div_cnt_reg <= div_cnt_reg + 4'd1;
        end
        if (cmd.err_calc) begin
            err_reg  <= err_val;
            herr_reg <= herr_val;
            x_reg    <= use_line ? 18'(err_val) : 18'(herr_val);
            d_reg    <= use_line ? 19'(err_val) - 19'(prev_lerr_reg)
                                 : 19'(herr_val) - 19'(prev_herr_reg);
            g1_reg   <= use_line ? line_kp_reg : head_kp_reg;
            g2_reg   <= use_line ? line_kd_reg : head_kd_reg;
            lim_reg  <= use_line ? $signed({2'b00, track_base_reg, 8'd0}) : HMAX_Q12;
        end
        if (cmd.mul) begin
            p1_reg <= $signed({1'b0, g1_reg}) * x_reg;
            p2_reg <= $signed({1'b0, g2_reg}) * d_reg;
        end
        if (cmd.sum) pd_reg <= pd_clamped;
        if (cmd.fin) begin
            out_left_reg  <= left_val;
            out_right_reg <= right_val;
            out_mode_reg  <= mode_next;
        end
    end

    assign status.div_done = (div_cnt_reg == DIV_LAST);
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid       = out_valid_reg;
    assign m_left_drive  = out_left_reg;
    assign m_right_drive = out_right_reg;
    assign m_mode        = out_mode_reg;

endmodule
`default_nettype wire

>>> hw/rtl/lfh_checker.sv
`default_nettype none
module lfh_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [10:0] m_left_drive,
    input wire logic signed [10:0] m_right_drive,
    input wire logic [2:0]         m_mode
);
    import lfh_pkg::*;

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a second item while busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_drive)
                                && $stable(m_right_drive) && $stable(m_mode))
        else $error("stalled result changed");

    // track drives forward only: left >= 0, right <= 0
    a_track_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mode == MODE_TRACK |-> m_left_drive >= 11'sd0
                                            && m_right_drive <= 11'sd0)
        else $error("track command drives backward");

endmodule

bind line_follow_heading_controller lfh_checker u_lfh_checker (.*);
`default_nettype wire

>>> bench/tb.sv
`default_nettype none
module tb;
    import lfh_pkg::*;

    localparam int ADV_TICKS   = 80;
    localparam int MIN_TICKS   = 50;
    localparam int CONF_TICKS  = 3;
    localparam int Q8_180      = 46080;
    localparam int Q8_360      = 92160;
    localparam int TURN_STEP   = 20480;
    localparam int TURN_TOL    = 1280;
    localparam int PD_LIMIT    = 409600;
    localparam int HOLD_TRIM   = -5;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 30;

    // one expected result item
    typedef struct {
        int         left;
        int         right;
        logic [2:0] mode;
    } drive_cmd_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_line_bits = 8'hFF;
    logic signed [16:0] s_heading = '0;
    logic               s_heading_valid = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b1;
    logic signed [10:0] m_left_drive;
    logic signed [10:0] m_right_drive;
    logic [2:0]         m_mode;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = REG_TRACK_BASE;
    logic [9:0]         cfg_data = '0;

    line_follow_heading_controller dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_line_bits(s_line_bits), .s_heading(s_heading),
        .s_heading_valid(s_heading_valid),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_left_drive(m_left_drive), .m_right_drive(m_right_drive), .m_mode(m_mode),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // shadow registers, indexed by register code
    int reg_val[8] = '{400, 800, 30, 5, 24, 13, 280, 180};

    // shadow controller state
    logic [2:0] c_mode;
    int c_ticks, c_confirm, c_tick, c_adv_start, c_right;
    int c_last_hdg, c_hold_tgt, c_turn_tgt, c_prev_line, c_prev_head;

    drive_cmd_t pending_cmds[$];
    int  mismatches = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;
    int  stall_left = 0;
    int  mode_hits[5] = '{0, 0, 0, 0, 0};
    int  heading_now = 0;

    function automatic int clampi(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int fold_180(input int e);
        int r;
        r = e;
        while (r > Q8_180) r -= Q8_360;
        while (r < -Q8_180) r += Q8_360;
        return r;
    endfunction

    function automatic int line_w(input int i);
        int w[8] = '{-7, -5, -3, -1, 1, 3, 5, 7};
        return w[i];
    endfunction

    task automatic go_hold(input int tgt);
        c_mode = MODE_BLIND; c_right = 0; c_hold_tgt = tgt;
        c_prev_head = 0; c_ticks = 0; c_confirm = 0;
    endtask

    task automatic go_advance(input int right);
        c_mode = MODE_ADV; c_right = right; c_adv_start = c_tick;
        c_prev_head = 0; c_ticks = 0; c_confirm = 0;
    endtask

    task automatic go_track();
        c_mode = MODE_TRACK; c_prev_line = 0; c_ticks = 0; c_confirm = 0;
    endtask

    task automatic bump_confirm();
        if (c_confirm < 7) c_confirm++;
    endtask

    // state update and wheel commands for one control tick
    task automatic predict_tick(input logic [7:0] bits, input int hdg, input bit hv,
                                output drive_cmd_t r);
        int nb, sum, err, pd, base, corr, e, o, b, s, mx;
        nb = 0; sum = 0;
        mx = reg_val[REG_MAX_SPEED];
        r.left = 0; r.right = 0;
        c_tick = (c_tick + 1) & 16'hFFFF;
        for (int i = 0; i < 8; i++)
            if (!bits[i]) begin
                nb++;
                sum += line_w(i);
            end
        if (hv) begin
            // mode machine
            if (c_ticks < 255) c_ticks++;
            if (c_mode == MODE_TRACK) begin
                if (nb > 0) c_last_hdg = hdg;
                if (c_ticks < MIN_TICKS) c_confirm = 0;
                else if (bits[7:4] == 4'h0 && bits[3:0] != 4'h0) go_advance(0);
                else if (bits[3:0] == 4'h0 && bits[7:4] != 4'h0) go_advance(1);
                else if (nb == 0) begin
                    bump_confirm();
                    if (c_confirm >= CONF_TICKS) go_hold(c_last_hdg);
                end else c_confirm = 0;
            end else if (c_mode == MODE_BLIND) begin
                if (c_ticks >= MIN_TICKS && nb > 0) begin
                    bump_confirm();
                    if (c_confirm >= CONF_TICKS) go_track();
                end else c_confirm = 0;
            end else if (c_mode > MODE_TR) begin
                go_track();
                c_prev_head = 0;
            end
            // drive law of the resulting mode
            if (c_mode == MODE_TRACK) begin
                base = reg_val[REG_TRACK_BASE];
                err = (nb == 0) ? c_prev_line : (sum * 256) / nb;
                pd = reg_val[REG_LINE_KP] * err + reg_val[REG_LINE_KD] * (err - c_prev_line);
                pd = clampi(pd, -base * 256, base * 256);
                c_prev_line = err;
                corr = -(pd / 256);
                r.left = clampi(base + corr, 0, mx);
                r.right = -clampi(base - corr, 0, mx);
            end else if (c_mode == MODE_BLIND) begin
                b = reg_val[REG_BLIND_BASE];
                e = fold_180(c_hold_tgt - hdg);
                pd = reg_val[REG_HEAD_KP] * e + reg_val[REG_HEAD_KD] * (e - c_prev_head);
                pd = clampi(pd, -PD_LIMIT, PD_LIMIT);
                c_prev_head = e;
                o = pd / 4096;
                r.left = clampi(b + HOLD_TRIM - o, 0, mx);
                r.right = -clampi(b + o, 0, mx);
            end else if (c_mode == MODE_ADV) begin
                s = clampi(reg_val[REG_BLIND_BASE], 0, mx);
                if (((c_tick - c_adv_start) & 16'hFFFF) >= ADV_TICKS) begin
                    // advance expired: spin toward 80 deg off the current heading
                    c_mode = c_right ? MODE_TR : MODE_TL;
                    c_turn_tgt = c_right ? hdg - TURN_STEP : hdg + TURN_STEP;
                    c_prev_head = 0; c_ticks = 0; c_confirm = 0;
                end
                r.left = s;
                r.right = -s;
            end else begin
                e = fold_180(c_turn_tgt - hdg);
                s = clampi(reg_val[REG_TURN_SPEED], 0, mx);
                if (e <= TURN_TOL && e >= -TURN_TOL) go_hold(c_turn_tgt);
                else if (c_mode == MODE_TL) begin
                    r.left = -s; r.right = -s;
                end else begin
                    r.left = s; r.right = s;
                end
            end
        end
        r.mode = c_mode;
    endtask

    // send one tick; the expectation is formed at the accepting edge
    task automatic send_tick(input logic [7:0] bits, input int hdg, input bit hv);
        drive_cmd_t r;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_line_bits <= bits;
        s_heading <= hdg[16:0];
        s_heading_valid <= hv;
        do @(posedge aclk); while (!s_ready);
        predict_tick(bits, hdg, hv, r);
        pending_cmds.push_back(r);
        items_sent++;
        if (r.mode <= MODE_TR) mode_hits[r.mode]++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[9:0];
        do @(posedge aclk); while (!cfg_ready);
        // 8-bit gains keep only their low bits
        case (idx)
            REG_LINE_KP, REG_LINE_KD, REG_HEAD_KP, REG_HEAD_KD: reg_val[idx] = val & 8'hFF;
            default: reg_val[idx] = val & 10'h3FF;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_regs(input int tb_v, input int mx, input int lkp, input int lkd,
                             input int hkp, input int hkd, input int bb, input int ts);
        wait_drained();
        write_reg(REG_TRACK_BASE, tb_v);
        write_reg(REG_MAX_SPEED, mx);
        write_reg(REG_LINE_KP, lkp);
        write_reg(REG_LINE_KD, lkd);
        write_reg(REG_HEAD_KP, hkp);
        write_reg(REG_HEAD_KD, hkd);
        write_reg(REG_BLIND_BASE, bb);
        write_reg(REG_TURN_SPEED, ts);
    endtask

    // field extremes, invalid heading, lost line and corner patterns before the
    // minimum dwell (no mode change allowed there)
    task automatic test_directed();
        logic [7:0] pats[12] = '{8'h00, 8'hFF, 8'hFE, 8'h7F, 8'hF0, 8'h0F,
                                 8'hE7, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hC3};
        send_tick(8'h00, Q8_180, 1'b0);
        send_tick(8'hFF, -Q8_180, 1'b0);
        foreach (pats[i]) send_tick(pats[i], (i % 2) ? Q8_180 : -Q8_180, 1'b1);
        send_tick(8'hFF, 0, 1'b1);
        send_tick(8'hFF, 1, 1'b1);
        send_tick(8'hFF, -1, 1'b1);
        send_tick(8'hE7, 32767, 1'b1);
        send_tick(8'hE7, -32768, 1'b1);
        wait_drained();
    endtask

    // random line bits that contain at least one black sensor
    function automatic logic [7:0] some_black();
        logic [7:0] v;
        v = 8'($urandom);
        if (v == 8'hFF) v[$urandom_range(0, 7)] = 1'b0;
        return v;
    endfunction

    // full course: track, corner or lost line, advance, spin, blind hold, back
    // to track; the tick content follows the predicted mode
    task automatic test_course(input int n);
        logic [7:0] bits;
        int step, err, pick;
        bit hv;
        for (int k = 0; k < n; k++) begin
            hv = ($urandom_range(0, 19) != 0);
            pick = $urandom_range(0, 99);
            heading_now = fold_180(heading_now + $urandom_range(0, 512) - 256);
            case (c_mode)
                MODE_TRACK: begin
                    if (c_ticks < MIN_TICKS - 1) bits = some_black();
                    else if (pick < 30) bits = {4'h0, 4'($urandom_range(1, 15))};
                    else if (pick < 60) bits = {4'($urandom_range(1, 15)), 4'h0};
                    else if (pick < 85) bits = 8'hFF;
                    else bits = some_black();
                end
                MODE_BLIND: begin
                    if (c_ticks < MIN_TICKS - 1) bits = (pick < 90) ? 8'hFF : some_black();
                    else bits = (pick < 75) ? some_black() : 8'hFF;
                end
                MODE_TL, MODE_TR: begin
                    bits = 8'($urandom);
                    err = fold_180(c_turn_tgt - heading_now);
                    step = $urandom_range(256, 8000);
                    heading_now = fold_180(heading_now + clampi(err, -step, step));
                end
                default: bits = 8'($urandom);
            endcase
            if (pick >= 97) heading_now = $urandom_range(0, 2 * Q8_180) - Q8_180;
            send_tick(bits, heading_now, hv);
        end
    endtask

    // pure noise ticks with random fields, heading within +-180 deg
    task automatic test_noise(input int n);
        for (int k = 0; k < n; k++)
            send_tick(8'($urandom), $urandom_range(0, 2 * Q8_180) - Q8_180,
                      1'($urandom_range(0, 1)));
    endtask

    // result checker
    always @(posedge aclk) begin
        drive_cmd_t x;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item at cycle %0d", cycles);
            end else begin
                x = pending_cmds.pop_front();
                if (m_left_drive !== 11'(x.left) || m_right_drive !== 11'(x.right)
                    || m_mode !== x.mode) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch item %0d: exp L=%0d R=%0d M=%0d got L=%0d R=%0d M=%0d",
                                 results_seen, x.left, x.right, x.mode,
                                 m_left_drive, m_right_drive, m_mode);
                end
            end
        end
    end

    // receiver stalls in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) m_ready <= 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 13);
            m_ready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL line_follow_heading_controller");
            $finish;
        end
    end

    initial begin
        c_mode = MODE_TRACK;
        c_ticks = 0; c_confirm = 0; c_tick = 0; c_adv_start = 0; c_right = 0;
        c_last_hdg = 0; c_hold_tgt = 0; c_turn_tgt = 0; c_prev_line = 0; c_prev_head = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_course(300);
        // everything at the top
        load_regs(1023, 1023, 255, 255, 255, 255, 1023, 1023);
        test_course(200);
        // everything at zero, gains written with high bits that must be dropped
        load_regs(0, 0, 768, 512, 256, 1024 - 256, 0, 0);
        test_course(100);
        // wheels clamp hard against a low max speed
        load_regs(900, 150, 200, 40, 120, 60, 700, 600);
        test_course(200);
        test_noise(60);
        load_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 1023), $urandom_range(0, 1023));
        test_course(200);
        load_regs(400, 800, 30, 5, 24, 13, 280, 180);
        // last stretch runs back to back on both sides
        idle_on = 1'b0;
        test_course(270);

        wait_drained();
        $display("sent %0d ticks, checked %0d results; per mode track/adv/blind/left/right:",
                 items_sent, results_seen);
        $display("  %0d / %0d / %0d / %0d / %0d", mode_hits[0], mode_hits[1], mode_hits[2],
                 mode_hits[3], mode_hits[4]);
        if (mismatches == 0 && pending_cmds.size() == 0) begin
            $display("PASS line_follow_heading_controller");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL line_follow_heading_controller");
        end
        $finish;
    end
endmodule
`default_nettype wire
